// ----- rtl/wsba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel slip brake arbiter package
// Widths, codes, reset values and shared types of the arbiter.
// ----------------------------------------------------------------------------
package wsba_pkg;

  localparam int TIMER_WIDTH       = 32;
  localparam int PULSE_COUNT_WIDTH = 8;

  localparam int WIDE_W      = (TIMER_WIDTH > 32) ? TIMER_WIDTH : 32;
  localparam int PULSE_CMP_W = (PULSE_COUNT_WIDTH > 8) ? PULSE_COUNT_WIDTH : 8;

  localparam int STALL_W      = 32;
  localparam int MIN_PULSES_W = 8;
  localparam int LEVER_W      = 8;
  localparam int COMPARE_W    = 12;
  localparam int CFG_DATA_W   = 32;

  localparam logic [STALL_W-1:0]      STALL_LIMIT_RST = 32'd10000;
  localparam logic [MIN_PULSES_W-1:0] MIN_PULSES_RST  = 8'd5;

  localparam int PERIOD_SHIFT = 4;
  localparam int LEVEL_SHIFT  = 4;
  localparam int LEVEL_OFFSET = 128;
  localparam int LEVEL_MAX    = 235;
  localparam int COMPARE_BASE = 1000;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_FRONT_EDGE = 2'd1,
    OP_REAR_EDGE  = 2'd2,
    OP_LEVER      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DEC_EQUAL = 2'b00,
    DEC_FRONT = 2'b01,
    DEC_REAR  = 2'b11
  } decision_t;

  typedef enum logic {
    CFG_STALL_LIMIT = 1'b0,
    CFG_MIN_PULSES  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    op_t                opcode;
    logic               edge_level;
    logic [LEVER_W-1:0] lever_sample;
  } item_t;

  typedef struct packed {
    logic [COMPARE_W-1:0] front_compare;
    logic [COMPARE_W-1:0] rear_compare;
    decision_t            wheel_decision;
  } result_t;

  typedef struct packed {
    logic [STALL_W-1:0]      stall_limit;
    logic [MIN_PULSES_W-1:0] min_moving_pulses;
  } cfg_t;

endpackage

// ----- rtl/wsba_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel slip brake arbiter input channel
// Valid/ready channel that carries one event word.
// ----------------------------------------------------------------------------
interface wsba_in_if import wsba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic               edge_level;
  logic [LEVER_W-1:0] lever_sample;

  modport source (output valid, output opcode, output edge_level, output lever_sample,
                  input ready);
  modport sink (input valid, input opcode, input edge_level, input lever_sample,
                output ready);
endinterface

// ----- rtl/wsba_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel slip brake arbiter result channel
// Valid/ready channel that carries the servo compare values and decision.
// ----------------------------------------------------------------------------
interface wsba_out_if import wsba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COMPARE_W-1:0] front_compare;
  logic [COMPARE_W-1:0] rear_compare;
  logic signed [1:0]    wheel_decision;

  modport source (output valid, output front_compare, output rear_compare,
                  output wheel_decision, input ready);
  modport sink (input valid, input front_compare, input rear_compare,
                input wheel_decision, output ready);
endinterface

// ----- rtl/wsba_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel slip brake arbiter configuration channel
// Valid/ready write channel with a register index and write data.
// ----------------------------------------------------------------------------
interface wsba_cfg_if import wsba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/wsba_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel slip brake arbiter configuration registers
// Holds the stall limit and the moving pulse threshold.
// ----------------------------------------------------------------------------
module wsba_cfg import wsba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  wsba_cfg_if.sink   cfg_bus,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_bus.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      unique case (cfg_index_t'(cfg_bus.index))
        CFG_STALL_LIMIT: cfg_nxt.stall_limit = cfg_bus.data[STALL_W-1:0];
        CFG_MIN_PULSES:  cfg_nxt.min_moving_pulses = cfg_bus.data[MIN_PULSES_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stall_limit       <= STALL_LIMIT_RST;
      cfg_r.min_moving_pulses <= MIN_PULSES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/wsba_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel slip brake arbiter core
// Wheel timers, period measurement, slip decision and servo compare values.
// ----------------------------------------------------------------------------
module wsba_core import wsba_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic [TIMER_WIDTH-1:0]       front_timer_r, front_timer_nxt;
  logic [TIMER_WIDTH-1:0]       rear_timer_r, rear_timer_nxt;
  logic [TIMER_WIDTH-1:0]       front_start_r, front_start_nxt;
  logic [TIMER_WIDTH-1:0]       rear_start_r, rear_start_nxt;
  logic [TIMER_WIDTH-1:0]       front_period_r, front_period_nxt;
  logic [TIMER_WIDTH-1:0]       rear_period_r, rear_period_nxt;
  logic [PULSE_COUNT_WIDTH-1:0] front_pulses_r, front_pulses_nxt;
  logic [PULSE_COUNT_WIDTH-1:0] rear_pulses_r, rear_pulses_nxt;
  decision_t                    decision_r, decision_nxt;

  logic                   front_stall, rear_stall;
  logic                   front_moving, rear_moving, blocked;
  logic [WIDE_W-1:0]      fp_w, rp_w, min_w, diff_w;
  logic [31:0]            min_x16;
  logic signed [31:0]     diff_s, lim_s, neg_lim_s;
  decision_t              cmp_dec;
  logic signed [LEVER_W+1:0] level_s;
  logic [LEVER_W-1:0]     level;
  logic [COMPARE_W-1:0]   applied;

  assign front_stall = WIDE_W'(front_timer_r) > WIDE_W'(cfg.stall_limit);
  assign rear_stall  = WIDE_W'(rear_timer_r) > WIDE_W'(cfg.stall_limit);
  assign rear_moving  = PULSE_CMP_W'(rear_pulses_r) >= PULSE_CMP_W'(cfg.min_moving_pulses);
  assign front_moving = PULSE_CMP_W'(front_pulses_r) >= PULSE_CMP_W'(cfg.min_moving_pulses);
  assign blocked = ((front_pulses_r == '0) || (rear_pulses_r == '0)) &&
                   (front_pulses_r < PULSE_COUNT_WIDTH'(2)) &&
                   (rear_pulses_r < PULSE_COUNT_WIDTH'(2));

  assign fp_w      = WIDE_W'(front_period_r);
  assign rp_w      = WIDE_W'(rear_period_r);
  assign min_w     = (fp_w < rp_w) ? fp_w : rp_w;
  assign diff_w    = fp_w - rp_w;
  assign min_x16   = {min_w[31-PERIOD_SHIFT:0], {PERIOD_SHIFT{1'b0}}};
  assign diff_s    = signed'(diff_w[31:0]);
  assign lim_s     = signed'(min_x16);
  assign neg_lim_s = signed'(32'd0 - min_x16);

  always_comb begin
    priority if (diff_s > lim_s) begin
      cmp_dec = DEC_FRONT;
    end else if (diff_s < neg_lim_s) begin
      cmp_dec = DEC_REAR;
    end else begin
      cmp_dec = DEC_EQUAL;
    end
  end

  always_comb begin
    front_timer_nxt  = front_timer_r;
    rear_timer_nxt   = rear_timer_r;
    front_start_nxt  = front_start_r;
    rear_start_nxt   = rear_start_r;
    front_period_nxt = front_period_r;
    rear_period_nxt  = rear_period_r;
    front_pulses_nxt = front_pulses_r;
    rear_pulses_nxt  = rear_pulses_r;
    decision_nxt     = decision_r;
    if (fire) begin
      unique case (item.opcode)
        OP_TICK: begin
          if (front_timer_r != '1) front_timer_nxt = front_timer_r + 1'b1;
          if (rear_timer_r != '1) rear_timer_nxt = rear_timer_r + 1'b1;
        end
        OP_FRONT_EDGE: begin
          if (item.edge_level) begin
            front_start_nxt = front_timer_r;
          end else begin
            front_period_nxt = front_timer_r - front_start_r;
            if (front_pulses_r != '1) front_pulses_nxt = front_pulses_r + 1'b1;
            front_timer_nxt = '0;
          end
        end
        OP_REAR_EDGE: begin
          if (item.edge_level) begin
            rear_start_nxt = rear_timer_r;
          end else begin
            rear_period_nxt = rear_timer_r - rear_start_r;
            if (rear_pulses_r != '1) rear_pulses_nxt = rear_pulses_r + 1'b1;
            rear_timer_nxt = '0;
          end
        end
        OP_LEVER: begin
          priority if (front_stall && rear_stall) begin
            decision_nxt = DEC_EQUAL;
          end else if (front_stall && rear_moving) begin
            front_timer_nxt = '0;
            decision_nxt    = DEC_FRONT;
          end else if (rear_stall && front_moving) begin
            rear_timer_nxt = '0;
            decision_nxt   = DEC_REAR;
          end else if (blocked) begin
            decision_nxt = decision_r;
          end else begin
            decision_nxt     = cmp_dec;
            front_period_nxt = '0;
            rear_period_nxt  = '0;
            front_pulses_nxt = '0;
            rear_pulses_nxt  = '0;
          end
        end
        default: decision_nxt = decision_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_timer_r  <= '0;
      rear_timer_r   <= '0;
      front_start_r  <= '0;
      rear_start_r   <= '0;
      front_period_r <= '0;
      rear_period_r  <= '0;
      front_pulses_r <= '0;
      rear_pulses_r  <= '0;
      decision_r     <= DEC_EQUAL;
    end else begin
      front_timer_r  <= front_timer_nxt;
      rear_timer_r   <= rear_timer_nxt;
      front_start_r  <= front_start_nxt;
      rear_start_r   <= rear_start_nxt;
      front_period_r <= front_period_nxt;
      rear_period_r  <= rear_period_nxt;
      front_pulses_r <= front_pulses_nxt;
      rear_pulses_r  <= rear_pulses_nxt;
      decision_r     <= decision_nxt;
    end
  end

  always_comb begin
    level_s = (LEVER_W+2)'(LEVEL_OFFSET) - signed'({2'b00, item.lever_sample});
    priority if (level_s < 0) begin
      level = '0;
    end else if (level_s > (LEVER_W+2)'(LEVEL_MAX)) begin
      level = LEVER_W'(LEVEL_MAX);
    end else begin
      level = level_s[LEVER_W-1:0];
    end
  end

  assign applied = COMPARE_W'(COMPARE_BASE) + COMPARE_W'({level, {LEVEL_SHIFT{1'b0}}});

  assign result.front_compare  = (decision_nxt == DEC_FRONT) ? COMPARE_W'(COMPARE_BASE)
                                                             : applied;
  assign result.rear_compare   = (decision_nxt == DEC_REAR) ? COMPARE_W'(COMPARE_BASE)
                                                            : applied;
  assign result.wheel_decision = decision_nxt;

endmodule

// ----- rtl/wheel_slip_brake_arbiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel slip brake arbiter
// Two-wheel anti-lock brake arbiter with input and result registers.
// ----------------------------------------------------------------------------
// The input channel takes one event word per handshake: a timer tick, a front
// or rear sensor edge with the pin level after it, or a brake lever sample.
// Ticks and edges update the wheel timers and period measurements and give no
// result. A lever sample gives one result word on the output channel with both
// servo compare values and the slip decision.
// The configuration channel writes the stall limit (index 0) and the moving
// pulse threshold (index 1); it is always ready and should be used while the
// block is idle.
// An accepted word is held in the input register and processed from there; a
// lever sample's result goes through the result register to the output.
// One word is accepted per cycle while the input register is free or passes
// its word on to the core.
// Reset clears all wheel state, restores the default configuration and
// empties both registers. When the receiver stalls, the result register holds
// its word; ticks and edges still pass, and a lever sample waits in the input
// register until the result register frees.
// ----------------------------------------------------------------------------
module wheel_slip_brake_arbiter import wsba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  wsba_in_if.sink    in_bus,
  wsba_out_if.source out_bus,
  wsba_cfg_if.sink   cfg_bus
);

  logic    in_valid_r, in_valid_nxt;
  item_t   item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t result_r;
  result_t core_result;
  cfg_t    cfg;
  logic    has_result;
  logic    fire;
  logic    in_take;

  wsba_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  wsba_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .cfg    (cfg),
    .result (core_result)
  );

  assign has_result   = (item_r.opcode == OP_LEVER);
  assign fire         = in_valid_r && (!has_result || !out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || fire;
  assign in_take      = in_bus.valid && in_bus.ready;

  assign in_valid_nxt  = in_take || (in_valid_r && !fire);
  assign out_valid_nxt = (fire && has_result) || (out_valid_r && !out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.opcode       <= op_t'(in_bus.opcode);
      item_r.edge_level   <= in_bus.edge_level;
      item_r.lever_sample <= in_bus.lever_sample;
    end
    if (fire && has_result) begin
      result_r <= core_result;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.front_compare  = result_r.front_compare;
  assign out_bus.rear_compare   = result_r.rear_compare;
  assign out_bus.wheel_decision = signed'(result_r.wheel_decision);

endmodule
